### hw/rtl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg - shared types and constants of the Morse key decoder
// Event codes, register indexes, reset values and the letter/digit table.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Event kinds on the result channel
  localparam logic [1:0] EV_KEY       = 2'd0;
  localparam logic [1:0] EV_BACKSPACE = 2'd1;
  localparam logic [1:0] EV_HAPTIC    = 2'd2;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DOT_LIMIT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LETTER_GAP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_GUARD = 2'd2;

  // Register reset values
  localparam logic [15:0] DOT_LIMIT_RST    = 16'd250;
  localparam logic [15:0] LETTER_GAP_RST   = 16'd1000;
  localparam logic [15:0] REPEAT_GUARD_RST = 16'd300;

  // Key codes
  localparam logic [7:0] KEY_A         = 8'h41;
  localparam logic [7:0] KEY_0         = 8'h30;
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_NONE      = 8'h00;

  localparam logic [15:0] TYPED_MAX = 16'hFFFF;

  // Result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;

  // Letter/digit table: bit j of the pattern set means symbol j is a dash
  localparam int unsigned N_CODES   = 36;
  localparam int unsigned N_LETTERS = 26;

  localparam logic [2:0] CODE_LEN [N_CODES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] CODE_PAT [N_CODES] = '{
    5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,  5'd14,
    5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,  5'd0,  5'd1,
    5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15
  };

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } lookup_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       last;
  } result_t;

  // Pattern lookup; count and pattern are zero-extended by the caller
  function automatic lookup_t letter_lookup(input logic [3:0] count,
                                            input logic [7:0] pattern);
    lookup_t r;
    r = '0;
    for (int i = 0; i < N_CODES; i++) begin
      if (count == {1'b0, CODE_LEN[i]} && pattern == {3'b000, CODE_PAT[i]}) begin
        r.hit = 1'b1;
        if (i < N_LETTERS) begin
          r.code = KEY_A + 8'(i);
        end else begin
          r.code = KEY_0 + 8'(i - N_LETTERS);
        end
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/morse_key_decoder_core.sv
// ----------------------------------------------------------------------------
// morse_key_decoder_core - Morse key decoder
// Turns button polls into haptic pulse, decoded key and backspace events.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in       | in_valid / in_ready     | now_ms, button_key/erase/enter
//  out      | out_valid / out_ready   | event_kind, key_code, last
//  cfg      | cfg_wr_en               | cfg_index, cfg_data
//
//  One poll is taken per cycle. Its whole effect on the state is worked out in
//  the accepting cycle and its zero to two results land in a four-entry queue.
//  The queue is registered and hands its results to out in arrival order.
//  in_ready drops while the queue has fewer than two free slots; the queue
//  drain of one result a cycle bounds the rate when polls make two results.
//  rst (synchronous) restores register defaults and empties the queue.
//
module morse_key_decoder_core #(
  parameter int MAX_SYMBOLS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  // poll requests
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    now_ms,
  input  logic                           button_key,
  input  logic                           button_erase,
  input  logic                           button_enter,
  // event requests
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     event_kind,
  output logic [7:0]                     key_code,
  output logic                           last,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [mkd_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SYMBOLS);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_SYMBOLS + 1);
  localparam logic [mkd_pkg::RQ_CNT_W-1:0] RQ_ROOM =
    mkd_pkg::RQ_CNT_W'(mkd_pkg::RQ_DEPTH - 2);

  // Configuration registers
  logic [15:0] dot_limit_ms;
  logic [15:0] letter_gap_ms;
  logic [15:0] repeat_guard_ms;

  // Decoder state
  logic                   key_held;
  logic [31:0]            press_start;
  logic [31:0]            last_symbol_time;
  logic [MAX_SYMBOLS-1:0] symbol_pattern;
  logic [CNT_W-1:0]       symbol_count;
  logic [31:0]            last_erase_time;
  logic [31:0]            last_enter_time;
  logic [15:0]            typed_count;

  // Result queue
  mkd_pkg::result_t               rq [mkd_pkg::RQ_DEPTH];
  logic [mkd_pkg::RQ_PTR_W-1:0]   wr_ptr;
  logic [mkd_pkg::RQ_PTR_W-1:0]   rd_ptr;
  logic [mkd_pkg::RQ_CNT_W-1:0]   rq_count;

  // Poll evaluation
  logic                   in_fire;
  logic                   out_fire;
  logic                   press;
  logic                   release_edge;
  logic                   is_dash;
  logic [31:0]            press_dur;
  logic [31:0]            since_symbol;
  logic [31:0]            since_erase;
  logic [31:0]            since_enter;
  logic                   letter_done;
  mkd_pkg::lookup_t       found;
  logic                   key_out;
  logic                   erase_ok;
  logic                   enter_ok;
  logic [15:0]            typed_dec;
  logic [15:0]            typed_ers;
  logic [15:0]            typed_count_next;
  logic [MAX_SYMBOLS-1:0] pattern_add;
  logic [1:0]             n_res;
  mkd_pkg::result_t       res0;
  mkd_pkg::result_t       res1;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (rq_count <= RQ_ROOM);

  // Key edges
  assign press        = button_key && !key_held;
  assign release_edge = !button_key && key_held;
  assign press_dur    = now_ms - press_start;
  assign is_dash      = (press_dur >= {16'd0, dot_limit_ms});

  always_comb begin
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      pattern_add[j] = symbol_pattern[j] || (is_dash && symbol_count == CNT_W'(j));
    end
  end

  // Letter timeout: a release restarts the gap, so it never ends a letter too
  assign since_symbol = now_ms - last_symbol_time;
  assign letter_done  = !release_edge && (symbol_count != '0) &&
                        (since_symbol > {16'd0, letter_gap_ms});
  assign found        = mkd_pkg::letter_lookup(4'(symbol_count), 8'(symbol_pattern));
  assign key_out      = letter_done && found.hit;

  assign typed_dec = (key_out && typed_count != mkd_pkg::TYPED_MAX) ?
                     typed_count + 16'd1 : typed_count;

  // Erase and enter, each rate-limited by the guard
  assign since_erase = now_ms - last_erase_time;
  assign since_enter = now_ms - last_enter_time;
  assign erase_ok    = button_erase && (since_erase > {16'd0, repeat_guard_ms}) &&
                       (typed_dec != 16'd0);
  assign enter_ok    = button_enter && (since_enter > {16'd0, repeat_guard_ms});

  assign typed_ers = erase_ok ? typed_dec - 16'd1 : typed_dec;
  assign typed_count_next = (enter_ok && typed_ers != mkd_pkg::TYPED_MAX) ?
                            typed_ers + 16'd1 : typed_ers;

  // Results in order: haptic or decoded key (never both), then backspace
  always_comb begin
    res0 = '0;
    res1 = '0;
    n_res = 2'd0;
    if (release_edge || key_out) begin
      res0.kind = release_edge ? mkd_pkg::EV_HAPTIC : mkd_pkg::EV_KEY;
      res0.code = release_edge ? mkd_pkg::KEY_NONE : found.code;
      if (erase_ok) begin
        res1.kind = mkd_pkg::EV_BACKSPACE;
        res1.code = mkd_pkg::KEY_BACKSPACE;
        res1.last = 1'b1;
        n_res = 2'd2;
      end else begin
        res0.last = 1'b1;
        n_res = 2'd1;
      end
    end else if (erase_ok) begin
      res0.kind = mkd_pkg::EV_BACKSPACE;
      res0.code = mkd_pkg::KEY_BACKSPACE;
      res0.last = 1'b1;
      n_res = 2'd1;
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_limit_ms    <= mkd_pkg::DOT_LIMIT_RST;
      letter_gap_ms   <= mkd_pkg::LETTER_GAP_RST;
      repeat_guard_ms <= mkd_pkg::REPEAT_GUARD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mkd_pkg::REG_DOT_LIMIT:    dot_limit_ms    <= cfg_data;
        mkd_pkg::REG_LETTER_GAP:   letter_gap_ms   <= cfg_data;
        mkd_pkg::REG_REPEAT_GUARD: repeat_guard_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state update, one poll per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      key_held         <= 1'b0;
      press_start      <= '0;
      last_symbol_time <= '0;
      symbol_pattern   <= '0;
      symbol_count     <= '0;
      last_erase_time  <= '0;
      last_enter_time  <= '0;
      typed_count      <= '0;
    end else if (in_fire) begin
      if (press) begin
        key_held    <= 1'b1;
        press_start <= now_ms;
      end else if (release_edge) begin
        key_held <= 1'b0;
      end

      if (release_edge) begin
        last_symbol_time <= now_ms;
        if (symbol_count < CNT_FULL) begin
          symbol_pattern <= pattern_add;
          symbol_count   <= symbol_count + CNT_W'(1);
        end else begin
          // overlong: mark it and ignore further symbols
          symbol_count <= CNT_OVER;
        end
      end else if (letter_done) begin
        symbol_pattern <= '0;
        symbol_count   <= '0;
      end

      if (erase_ok) begin
        last_erase_time <= now_ms;
      end
      if (enter_ok) begin
        last_enter_time <= now_ms;
      end
      typed_count <= typed_count_next;
    end
  end

  // Result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      rq_count <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + mkd_pkg::RQ_PTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      rq_count <= rq_count + (in_fire ? mkd_pkg::RQ_CNT_W'(n_res) : '0)
                           - mkd_pkg::RQ_CNT_W'(out_fire);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      rq[wr_ptr] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      rq[wr_ptr + 1'b1] <= res1;
    end
  end

  assign out_valid  = (rq_count != '0);
  assign event_kind = rq[rd_ptr].kind;
  assign key_code   = rq[rd_ptr].code;
  assign last       = rq[rd_ptr].last;

endmodule

### hw/rtl/mkd_checker.sv
// ----------------------------------------------------------------------------
// mkd_checker - port-level checks of the Morse key decoder
// Watches the event channel and reset behaviour.
// ----------------------------------------------------------------------------
module mkd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [7:0] key_code
);

  // stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(key_code))
    else $error("event request changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("event pending straight after reset");

  a_haptic_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == mkd_pkg::EV_HAPTIC |-> key_code == mkd_pkg::KEY_NONE)
    else $error("haptic pulse with nonzero key code");

  a_bksp_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == mkd_pkg::EV_BACKSPACE |-> key_code == mkd_pkg::KEY_BACKSPACE)
    else $error("backspace with wrong key code");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == mkd_pkg::EV_KEY |->
      (key_code >= 8'h30 && key_code <= 8'h39) || (key_code >= 8'h41 && key_code <= 8'h5A))
    else $error("decoded key outside letters and digits");

endmodule

bind morse_key_decoder_core mkd_checker u_mkd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_kind (event_kind),
  .key_code   (key_code)
);

### bench/tb_morse_key_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_key_decoder_core - self-checking bench for the Morse key decoder
// Feeds poll requests with random idling, predicts the pulse, key and
// backspace event requests of each poll and checks them in order while the
// output side stalls at random, and every HOLD_EVERY events for a long stretch.
// ----------------------------------------------------------------------------
module tb_morse_key_decoder_core;

  localparam int MAX_SYMBOLS = 5;
  localparam int N_TABLE     = 36;
  localparam int LONG_HOLD   = 80;    // output hold-off, long enough to fill the queue
  localparam int HOLD_EVERY  = 120;   // events between long hold-offs
  localparam int STALL_LIMIT = 2000;  // cycles with no request moving
  localparam int SETTLE      = 4;     // cycles left for polls that raise no event
  localparam logic [mkd_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index

  typedef struct {
    logic [31:0] now;
    logic        key;
    logic        erase;
    logic        enter;
    int unsigned gap;   // idle cycles before the poll is offered
  } poll_t;

  // DUT ports
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [31:0]                   now_ms = '0;
  logic                          button_key = 1'b0;
  logic                          button_erase = 1'b0;
  logic                          button_enter = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    event_kind;
  logic [7:0]                    key_code;
  logic                          last;
  logic                          cfg_wr_en = 1'b0;
  logic [mkd_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;

  // Letters A-Z then digits 0-9, dot '.', dash '-'
  string morse_codes [N_TABLE] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };

  // Register mirror, only touched while the block is idle
  logic [15:0] dot_ms_cfg   = mkd_pkg::DOT_LIMIT_RST;
  logic [15:0] gap_ms_cfg   = mkd_pkg::LETTER_GAP_RST;
  logic [15:0] guard_ms_cfg = mkd_pkg::REPEAT_GUARD_RST;

  // Decoder state as it stands after the last accepted poll
  logic        key_down  = 1'b0;
  logic [31:0] press_ms  = '0;
  logic [31:0] symbol_ms = '0;
  logic [7:0]  dash_bits = '0;   // bit j set: symbol j is a dash
  int          sym_len   = 0;    // MAX_SYMBOLS+1 marks an overlong letter
  logic [31:0] erase_ms  = '0;
  logic [31:0] enter_ms  = '0;
  logic [15:0] typed     = '0;

  poll_t            poll_backlog [$];
  mkd_pkg::result_t pending_events [$];

  // Driver / monitor bookkeeping
  poll_t            offered;
  int unsigned      gap_left = 0;
  bit               gap_armed = 1'b0;
  int               rx_hold = 0;
  int unsigned      tx_max = 4;
  int unsigned      rx_max = 4;
  mkd_pkg::result_t want_ev;
  int               events_seen = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  // Stimulus generator state
  logic [31:0] stamp = '0;
  logic        key_level = 1'b0;
  int          polls_made = 0;

  morse_key_decoder_core #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .now_ms       (now_ms),
    .button_key   (button_key),
    .button_erase (button_erase),
    .button_enter (button_enter),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .key_code     (key_code),
    .last         (last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Event prediction
  // --------------------------------------------------------------------------

  function automatic bit spells(string marks, logic [7:0] bits, int len);
    if (marks.len() != len) return 1'b0;
    for (int j = 0; j < len; j++) begin
      if ((marks[j] == "-") != bits[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the events of one poll in the order key edge, letter timeout,
  // erase, enter, and queues them with last set on the final one.
  task automatic predict_poll(input poll_t p);
    mkd_pkg::result_t ev;
    mkd_pkg::result_t batch [$];
    logic [31:0]      held_for;
    logic [31:0]      idle_for;
    int               hit;
    hit = -1;
    ev.last = 1'b0;
    if (p.key && !key_down) begin
      key_down = 1'b1;
      press_ms = p.now;
    end else if (!p.key && key_down) begin
      held_for = p.now - press_ms;
      key_down = 1'b0;
      if (sym_len < MAX_SYMBOLS) begin
        // a zero dot limit turns every press into a dash
        if (held_for >= {16'd0, dot_ms_cfg}) dash_bits[sym_len] = 1'b1;
        sym_len++;
      end else begin
        sym_len = MAX_SYMBOLS + 1;
      end
      ev.kind = mkd_pkg::EV_HAPTIC;
      ev.code = mkd_pkg::KEY_NONE;
      batch.push_back(ev);
      symbol_ms = p.now;   // so no decode in the poll that ends a symbol
    end
    // timeout runs even while the key is still down
    idle_for = p.now - symbol_ms;
    if (sym_len != 0 && idle_for > {16'd0, gap_ms_cfg}) begin
      for (int i = 0; i < N_TABLE; i++) begin
        if (hit < 0 && spells(morse_codes[i], dash_bits, sym_len)) hit = i;
      end
      if (hit >= 0) begin
        if (typed != mkd_pkg::TYPED_MAX) typed++;
        ev.kind = mkd_pkg::EV_KEY;
        ev.code = (hit < mkd_pkg::N_LETTERS) ?
                  mkd_pkg::KEY_A + 8'(hit) :
                  mkd_pkg::KEY_0 + 8'(hit - mkd_pkg::N_LETTERS);
        batch.push_back(ev);
      end
      dash_bits = '0;
      sym_len = 0;
    end
    idle_for = p.now - erase_ms;
    if (p.erase && idle_for > {16'd0, guard_ms_cfg} && typed != 0) begin
      typed--;
      ev.kind = mkd_pkg::EV_BACKSPACE;
      ev.code = mkd_pkg::KEY_BACKSPACE;
      batch.push_back(ev);
      erase_ms = p.now;
    end
    idle_for = p.now - enter_ms;
    if (p.enter && idle_for > {16'd0, guard_ms_cfg}) begin
      if (typed != mkd_pkg::TYPED_MAX) typed++;
      enter_ms = p.now;
    end
    foreach (batch[k]) begin
      ev = batch[k];
      ev.last = (k == batch.size() - 1);
      pending_events.push_back(ev);
    end
  endtask

  // --------------------------------------------------------------------------
  // Poll driver: each poll waits its drawn gap, then stays offered until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_armed = 1'b0;
    end else begin
      if (in_valid && in_ready) predict_poll(offered);
      if (!(in_valid && !in_ready)) begin
        if (poll_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left = poll_backlog[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
          end else begin
            offered = poll_backlog.pop_front();
            gap_armed = 1'b0;
            in_valid     <= 1'b1;
            now_ms       <= offered.now;
            button_key   <= offered.key;
            button_erase <= offered.erase;
            button_enter <= offered.enter;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event monitor: checks each request against the oldest prediction, then
  // draws its own stall; every HOLD_EVERY events it holds off for a long
  // stretch so the result queue fills and in_ready drops.
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          flag_mismatch($sformatf("event %0d not expected: kind %0d code %02h last %0b",
                                  events_seen, event_kind, key_code, last));
        end else begin
          want_ev = pending_events.pop_front();
          if (event_kind !== want_ev.kind)
            flag_mismatch($sformatf("event %0d kind %0d, want %0d",
                                    events_seen, event_kind, want_ev.kind));
          if (key_code !== want_ev.code)
            flag_mismatch($sformatf("event %0d code %02h, want %02h",
                                    events_seen, key_code, want_ev.code));
          if (last !== want_ev.last)
            flag_mismatch($sformatf("event %0d last %0b, want %0b",
                                    events_seen, last, want_ev.last));
        end
        events_seen++;
        if (events_seen % HOLD_EVERY == 0) rx_hold = LONG_HOLD;
        else rx_hold = $urandom_range(0, rx_max);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: no request moving on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("[%0t] timeout: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic offer(input logic [31:0] when, input logic key, input logic erase,
                       input logic enter);
    poll_t p;
    p.now   = when;
    p.key   = key;
    p.erase = erase;
    p.enter = enter;
    p.gap   = $urandom_range(0, tx_max);
    poll_backlog.push_back(p);
    key_level = key;
    polls_made++;
  endtask

  // Keys one letter: press/release per symbol, then a poll past the letter gap
  // (sometimes preceded by one exactly on the gap, which must not decode).
  task automatic key_symbols(input string marks, input logic erase_at_end);
    int unsigned held_for;
    for (int j = 0; j < marks.len(); j++) begin
      stamp += $urandom_range(0, gap_ms_cfg / 4);
      offer(stamp, 1'b1, 1'b0, 1'b0);
      if (marks[j] == "-") held_for = dot_ms_cfg + $urandom_range(0, dot_ms_cfg / 2 + 3);
      else if (dot_ms_cfg == 0) held_for = 0;
      else held_for = $urandom_range(0, dot_ms_cfg - 1);
      if ($urandom_range(0, 7) == 0) offer(stamp + held_for / 2, 1'b1, 1'b0, 1'b0);
      stamp += held_for;
      offer(stamp, 1'b0, $urandom_range(0, 5) == 0, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) begin
      stamp += gap_ms_cfg;
      offer(stamp, 1'b0, 1'b0, 1'b0);
      stamp += 1;
    end else begin
      stamp += gap_ms_cfg + $urandom_range(1, 40);
    end
    offer(stamp, 1'b0, erase_at_end, 1'b0);
  endtask

  // Spacing for erase/enter: on the guard, just past it, or anywhere up to just past it
  function automatic int unsigned guard_step();
    case ($urandom_range(0, 2))
      0:       return guard_ms_cfg;
      1:       return guard_ms_cfg + 1;
      default: return $urandom_range(0, guard_ms_cfg + 1);
    endcase
  endfunction

  task automatic random_session(input int items);
    int    stop_at;
    string marks;
    stop_at = polls_made + items;
    while (polls_made < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key_symbols(morse_codes[$urandom_range(0, N_TABLE - 1)],
                                $urandom_range(0, 3) == 0);
        4, 5: begin
          // arbitrary pattern, up to two symbols too long
          marks = "";
          repeat ($urandom_range(1, MAX_SYMBOLS + 2)) begin
            if ($urandom_range(0, 1) == 1) marks = {marks, "-"};
            else marks = {marks, "."};
          end
          key_symbols(marks, $urandom_range(0, 3) == 0);
        end
        6: repeat ($urandom_range(1, 3)) begin
          stamp += guard_step();
          offer(stamp, key_level, 1'b1, $urandom_range(0, 3) == 0);
        end
        7: repeat ($urandom_range(1, 3)) begin
          stamp += guard_step();
          offer(stamp, key_level, $urandom_range(0, 3) == 0, 1'b1);
        end
        8: begin
          stamp = $urandom;
          offer(stamp, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
        end
        default: begin
          stamp += $urandom_range(0, 2 * gap_ms_cfg + 2);
          offer(stamp, key_level, 1'b0, 1'b0);
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [mkd_pkg::REG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mkd_pkg::REG_DOT_LIMIT:    dot_ms_cfg = val;
      mkd_pkg::REG_LETTER_GAP:   gap_ms_cfg = val;
      mkd_pkg::REG_REPEAT_GUARD: guard_ms_cfg = val;
      default: ;        // unmapped index is dropped
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Every poll taken and every predicted event seen, plus settling time
  task automatic wait_quiet();
    do @(negedge clk);
    while (poll_backlog.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed polls at reset settings (dot 250, gap 1000, guard 300)
    offer(32'd0,    1'b0, 1'b0, 1'b0);
    offer(32'd400,  1'b0, 1'b1, 1'b0);   // erase with nothing typed
    offer(32'd1000, 1'b1, 1'b0, 1'b0);
    offer(32'd1100, 1'b0, 1'b0, 1'b0);   // dot, pulse
    offer(32'd2100, 1'b0, 1'b0, 1'b0);   // exactly on the gap: no decode
    offer(32'd2101, 1'b0, 1'b1, 1'b0);   // E then backspace in one poll
    offer(32'd3000, 1'b1, 1'b0, 1'b0);
    offer(32'd3250, 1'b0, 1'b0, 1'b0);   // held exactly the dot limit: dash
    offer(32'd3300, 1'b1, 1'b0, 1'b0);
    offer(32'd3549, 1'b0, 1'b0, 1'b0);   // one below: dot
    offer(32'd3600, 1'b1, 1'b0, 1'b0);
    offer(32'd4600, 1'b1, 1'b0, 1'b0);   // N decoded while the key is down
    offer(32'd4700, 1'b0, 1'b1, 1'b1);   // pulse, backspace, enter
    offer(32'd5000, 1'b0, 1'b1, 1'b0);   // erase on the guard: ignored
    offer(32'd5001, 1'b0, 1'b0, 1'b1);   // enter just past the guard
    offer(32'd5701, 1'b0, 1'b0, 1'b0);   // T
    // overlong letter straddling the 32-bit wrap of the tick count
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      offer(32'hFFFF_FF00 + 32'(j * 32), 1'b1, 1'b0, 1'b0);
      offer(32'hFFFF_FF10 + 32'(j * 32), 1'b0, 1'b0, 1'b0);
    end
    offer(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0);
    offer(32'h0000_0100, 1'b0, 1'b0, 1'b0);   // dash across the wrap
    offer(32'h0000_0500, 1'b0, 1'b0, 1'b0);   // timeout: cleared, no key
    stamp = 32'h0000_0500;
    wait_quiet();

    // Low extremes: zero dot limit, a letter gap of 1, no guard
    write_reg(mkd_pkg::REG_DOT_LIMIT, 16'd0);
    write_reg(mkd_pkg::REG_LETTER_GAP, 16'd1);
    write_reg(mkd_pkg::REG_REPEAT_GUARD, 16'd0);
    end_writes();
    random_session(110);
    wait_quiet();

    // High extremes, output ready but for the long hold-offs
    write_reg(mkd_pkg::REG_DOT_LIMIT, 16'hFFFF);
    write_reg(mkd_pkg::REG_LETTER_GAP, 16'hFFFF);
    write_reg(mkd_pkg::REG_REPEAT_GUARD, 16'hFFFF);
    end_writes();
    tx_max = 2;
    rx_max = 0;
    stamp = 32'hFFF0_0000;
    random_session(100);
    wait_quiet();

    // Unmapped index must change nothing; no random idling on either side
    write_reg(REG_SPARE, 16'h5AA5);
    write_reg(mkd_pkg::REG_DOT_LIMIT, 16'd1);
    write_reg(mkd_pkg::REG_LETTER_GAP, 16'd200);
    write_reg(mkd_pkg::REG_REPEAT_GUARD, 16'd50);
    end_writes();
    tx_max = 0;
    random_session(100);
    wait_quiet();

    // Typical timing, input pushing every cycle against a stalling output
    write_reg(mkd_pkg::REG_DOT_LIMIT, 16'd120);
    write_reg(mkd_pkg::REG_LETTER_GAP, 16'd600);
    write_reg(mkd_pkg::REG_REPEAT_GUARD, 16'd150);
    end_writes();
    rx_max = 4;
    random_session(170);
    wait_quiet();

    // Guard off: a decode, then erases and enters one tick apart
    write_reg(mkd_pkg::REG_REPEAT_GUARD, 16'd0);
    end_writes();
    tx_max = 4;
    key_symbols(".", 1'b0);
    repeat (4) begin
      stamp += 1;
      offer(stamp, 1'b0, 1'b1, 1'b0);
    end
    repeat (4) begin
      stamp += 1;
      offer(stamp, 1'b0, 1'b0, 1'b1);
    end
    random_session(40);

    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### morse_key_decoder_core.f
hw/rtl/mkd_pkg.sv
hw/rtl/morse_key_decoder_core.sv
hw/rtl/mkd_checker.sv
bench/tb_morse_key_decoder_core.sv
